### hdl/chash_pkg.sv
// Shared types and constants of the chained hash table.
package chash_pkg;

   localparam int BUCKETS          = 13;
   localparam int SLOTS_PER_BUCKET = 8;
   localparam int TABLE_SLOTS      = BUCKETS * SLOTS_PER_BUCKET;

   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 31;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 4;

   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int ADDR_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W  = $clog2(SLOTS_PER_BUCKET + 1);

   // bucket = key - floor(key * RECIP >> SHIFT) * BUCKETS, exact for all keys
   localparam int SHIFT   = KEY_W + BKT_W;
   localparam int RECIP_W = KEY_W + 1;
   localparam int PROD_W  = KEY_W + RECIP_W;
   localparam logic [PROD_W-1:0] ONE_WIDE   = PROD_W'(1);
   localparam logic [PROD_W-1:0] RECIP_WIDE =
      ((ONE_WIDE << SHIFT) + PROD_W'(BUCKETS - 1)) / PROD_W'(BUCKETS);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_SEARCH = 2'd1,
      FUNC_REMOVE = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_REM,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_req;
      logic mul_en;
      logic start;
      logic issue;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_slot;
      logic out_free;
   } dp_stat_type;

endpackage

### hdl/chash_ctrl.sv
// Sequencer of the chained hash table: hash, slot scan, result handoff.
module chash_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  chash_pkg::dp_stat_type  stat,
   output chash_pkg::ctrl_cmd_type cmd
);
   import chash_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL:   state_in = ST_REM;
         ST_REM:   state_in = ST_SCAN;
         ST_SCAN: begin
            if (stat.last_slot) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_FINISH;
         ST_FINISH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_MUL:    cmd.mul_en   = 1'b1;
         ST_REM:    cmd.start    = 1'b1;
         ST_SCAN:   cmd.issue    = 1'b1;
         ST_DRAIN:  cmd          = '0;
         ST_FINISH: cmd.load_rsp = stat.out_free;
         default:   cmd          = '0;
      endcase
   end

endmodule

### hdl/chash_dp.sv
// Datapath: bucket hash, key memory, valid bits, scan compare, result register.
module chash_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  chash_pkg::ctrl_cmd_type            cmd,
   output chash_pkg::dp_stat_type             stat,
   input  logic [chash_pkg::FUNC_W-1:0]       req_func,
   input  logic [chash_pkg::KEY_W-1:0]        req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [chash_pkg::STATUS_W-1:0]     rsp_status,
   output logic [chash_pkg::KEY_W-1:0]        rsp_found_key,
   output logic [chash_pkg::COUNT_W-1:0]      rsp_removed_count
);
   import chash_pkg::*;

   logic [FUNC_W-1:0]      func_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic [BKT_W-1:0]       bucket_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [SLOT_W-1:0]      slot_q_ff;
   logic                   chk_ff;
   logic                   vld_q_ff;
   logic [KEY_W-1:0]       rd_key_ff;
   logic [TABLE_SLOTS-1:0] vld_ff, vld_in;
   logic                   ins_done_ff;
   logic                   hit_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]       rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]     rsp_count_ff;

   logic [KEY_W-1:0]       key_mem [TABLE_SLOTS];

   logic [KEY_W-1:0]       quot;
   logic [KEY_W-1:0]       rem;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      wr_addr;
   logic                   match;
   logic                   do_ins;
   logic                   do_rmv;
   logic                   do_hit;
   logic [CNT_W+COUNT_W-1:0] cnt_wide;

   // quotient from the reciprocal product, then remainder
   always_comb begin
      quot = KEY_W'(prod_ff >> SHIFT);
      rem  = key_ff - quot * KEY_W'(BUCKETS);
   end

   assign rd_addr = ADDR_W'(bucket_ff) * ADDR_W'(SLOTS_PER_BUCKET) + ADDR_W'(slot_ff);
   assign wr_addr = ADDR_W'(bucket_ff) * ADDR_W'(SLOTS_PER_BUCKET) + ADDR_W'(slot_q_ff);

   // compare stage works on the slot read in the previous cycle
   assign match  = vld_q_ff && (rd_key_ff == key_ff);
   assign do_ins = chk_ff && (func_ff == FUNC_INSERT) && !vld_q_ff && !ins_done_ff;
   assign do_rmv = chk_ff && (func_ff == FUNC_REMOVE) && match;
   assign do_hit = chk_ff && (func_ff == FUNC_SEARCH) && match;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         key_ff  <= req_key;
      end
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(key_ff) * PROD_W'(RECIP);
      end
      if (cmd.start) begin
         bucket_ff <= BKT_W'(rem);
      end
      if (cmd.start) begin
         slot_ff <= '0;
      end else if (cmd.issue) begin
         slot_ff <= slot_ff + SLOT_W'(1);
      end
      if (cmd.issue) begin
         slot_q_ff <= slot_ff;
         vld_q_ff  <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (do_ins) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (cmd.issue) begin
         rd_key_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ins_done_ff <= 1'b0;
         hit_ff      <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         if (do_ins) ins_done_ff <= 1'b1;
         if (do_hit) hit_ff      <= 1'b1;
         if (do_rmv) cnt_ff      <= cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (do_ins) vld_in[wr_addr] = 1'b1;
      if (do_rmv) vld_in[wr_addr] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         chk_ff       <= cmd.issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_status_in = STAT_MISS;
      rsp_found_in  = '0;
      case (func_ff)
         FUNC_INSERT: rsp_status_in = ins_done_ff ? STAT_DONE : STAT_FULL;
         FUNC_SEARCH: begin
            rsp_status_in = hit_ff ? STAT_DONE : STAT_MISS;
            rsp_found_in  = hit_ff ? key_ff : '0;
         end
         FUNC_REMOVE: rsp_status_in = (cnt_ff != '0) ? STAT_DONE : STAT_MISS;
         default:     rsp_status_in = STAT_MISS;
      endcase
   end

   assign cnt_wide = (func_ff == FUNC_REMOVE) ? {COUNT_W'(0), cnt_ff} : '0;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_count_ff  <= cnt_wide[COUNT_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign stat.last_slot = (slot_ff == SLOT_W'(SLOTS_PER_BUCKET - 1));
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_key     = rsp_found_ff;
   assign rsp_removed_count = rsp_count_ff;

endmodule

### hdl/chained_hash_table.sv
// Top level of the chained hash table: sequencer plus datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_func, req_key
//   rsp      out        rsp_valid / rsp_ready  rsp_status, rsp_found_key,
//                                              rsp_removed_count
//
// A request runs from accept to the next accept through the reciprocal-multiply
// hash (multiply, then remainder and bucket load), a scan of every slot of the
// bucket on the key memory read port, a compare drain, the result load and the
// idle state in which the next request is accepted.
// Reset clears the state machine, all slot valid bits and the result valid flag.
// A result that is not taken holds in the output register while the next
// request is accepted; the load of a further result waits until it is taken.
module chained_hash_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [chash_pkg::FUNC_W-1:0]   req_func,
   input  logic [chash_pkg::KEY_W-1:0]    req_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [chash_pkg::STATUS_W-1:0] rsp_status,
   output logic [chash_pkg::KEY_W-1:0]    rsp_found_key,
   output logic [chash_pkg::COUNT_W-1:0]  rsp_removed_count
);
   import chash_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   chash_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   chash_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_key           (req_key),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found_key     (rsp_found_key),
      .rsp_removed_count (rsp_removed_count)
   );

endmodule

### hdl/chash_chk.sv
// Port-level checker for the chained hash table, bound to the top level.
module chash_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [chash_pkg::STATUS_W-1:0] rsp_status,
   input logic [chash_pkg::KEY_W-1:0]    rsp_found_key,
   input logic [chash_pkg::COUNT_W-1:0]  rsp_removed_count
);
   import chash_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found_key) && $stable(rsp_removed_count))
      else $error("stalled result changed");

   // busy right after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_FULL) |->
         (rsp_found_key == '0) && (rsp_removed_count == '0))
      else $error("bucket full result carries data");

   a_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_removed_count != '0) |->
         (rsp_status == STAT_DONE) && (rsp_found_key == '0))
      else $error("remove count with wrong status");

   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_found_key != '0) |->
         (rsp_status == STAT_DONE) && (rsp_removed_count == '0))
      else $error("found key with wrong status");

endmodule

bind chained_hash_table chash_chk u_chk (.*);
